[design/odometry_pose_delta_integrator_assert.svh]
// Assertion macros for the odometry pose delta integrator.
`ifndef ODOMETRY_POSE_DELTA_INTEGRATOR_ASSERT_SVH
`define ODOMETRY_POSE_DELTA_INTEGRATOR_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define OPDI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define OPDI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/opdi_pkg.sv]
// ----------------------------------------------------------------------------
// opdi_pkg
// Shared types, constants and tables of the pose delta integrator.
// ----------------------------------------------------------------------------
package opdi_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int NUM_STEPS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int STEP_W       = $clog2(ATAN_LEN + 1);
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;

    localparam logic signed [33:0] CORDIC_GAIN0 = 34'sd652032874;

    localparam logic [15:0] RESET_MIN_TRANSLATION = 16'd3277;
    localparam logic [14:0] RESET_MIN_ROTATION    = 15'd910;

    localparam logic REG_MIN_TRANSLATION = 1'b0;
    localparam logic REG_MIN_ROTATION    = 1'b1;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_yaw;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [15:0] delta_yaw;
        logic signed [31:0] path_x;
        logic signed [31:0] path_y;
        logic signed [15:0] path_yaw;
        logic [31:0]        accepted_count;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic signed [15:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_q30;
        logic signed [33:0] sin_q30;
    } cordic_rsp_t;

    function automatic logic signed [33:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic signed [33:0] r;
        unique case (idx)
            5'd0:    r = 34'sd536870912;
            5'd1:    r = 34'sd316933406;
            5'd2:    r = 34'sd167458907;
            5'd3:    r = 34'sd85004756;
            5'd4:    r = 34'sd42667331;
            5'd5:    r = 34'sd21354465;
            5'd6:    r = 34'sd10679838;
            5'd7:    r = 34'sd5340245;
            5'd8:    r = 34'sd2670163;
            5'd9:    r = 34'sd1335087;
            5'd10:   r = 34'sd667544;
            5'd11:   r = 34'sd333772;
            5'd12:   r = 34'sd166886;
            5'd13:   r = 34'sd83443;
            5'd14:   r = 34'sd41722;
            5'd15:   r = 34'sd20861;
            5'd16:   r = 34'sd10430;
            5'd17:   r = 34'sd5215;
            5'd18:   r = 34'sd2608;
            5'd19:   r = 34'sd1304;
            5'd20:   r = 34'sd652;
            5'd21:   r = 34'sd326;
            5'd22:   r = 34'sd163;
            5'd23:   r = 34'sd81;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[design/odometry_pose_delta_integrator.sv]
// ----------------------------------------------------------------------------
// odometry_pose_delta_integrator
// Planar keyframe delta and dead-reckoning integrator, top level.
// ----------------------------------------------------------------------------
// The single iterative CORDIC unit is used once per pose for the keyframe
// heading and, only when the motion is kept, once more for the path heading.
// A two-entry input queue takes transfers while the back end works, and the
// output register holds a finished result until its transfer completes.
// Threshold registers are written through the cfg port with no wait state.
module odometry_pose_delta_integrator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  opdi_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output opdi_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata
);

    logic [15:0]        min_translation_reg;
    logic [14:0]        min_rotation_reg;
    logic               q_valid;
    logic               q_pop;
    opdi_pkg::in_item_t q_data;

    // Only two registers exist, so a one-bit index covers every write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_translation_reg <= opdi_pkg::RESET_MIN_TRANSLATION;
            min_rotation_reg    <= opdi_pkg::RESET_MIN_ROTATION;
        end else if (cfg_we) begin
            unique case (cfg_index)
                opdi_pkg::REG_MIN_TRANSLATION: min_translation_reg <= cfg_wdata;
                opdi_pkg::REG_MIN_ROTATION:    min_rotation_reg    <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    opdi_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    opdi_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .min_translation (min_translation_reg),
        .min_rotation    (min_rotation_reg),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_data          (q_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

[design/opdi_cordic.sv]
// ----------------------------------------------------------------------------
// opdi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q4.30 out.
// ----------------------------------------------------------------------------
module opdi_cordic (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  opdi_pkg::cordic_req_t req,
    output opdi_pkg::cordic_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          flip_reg, flip_next;
    logic [opdi_pkg::STEP_W-1:0]   step_reg, step_next;
    logic signed [33:0]            x_reg, x_next;
    logic signed [33:0]            y_reg, y_next;
    logic signed [33:0]            z_reg, z_next;
    logic                          done_reg, done_next;
    logic [31:0]                   phase;
    logic                          flip;
    logic [31:0]                   phase_adj;

    assign phase     = {req.angle, 16'h0000};
    assign flip      = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
    assign phase_adj = flip ? (phase + 32'h80000000) : phase;

    always_comb begin
        busy_next = busy_reg;
        flip_next = flip_reg;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            flip_next = flip;
            step_next = '0;
            x_next    = opdi_pkg::CORDIC_GAIN0;
            y_next    = '0;
            z_next    = {{2{phase_adj[31]}}, phase_adj};
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_next = x_reg - (y_reg >>> step_reg);
                y_next = y_reg + (x_reg >>> step_reg);
                z_next = z_reg - opdi_pkg::atan_entry(step_reg);
            end else begin
                x_next = x_reg + (y_reg >>> step_reg);
                y_next = y_reg - (x_reg >>> step_reg);
                z_next = z_reg + opdi_pkg::atan_entry(step_reg);
            end
            step_next = step_reg + 1'b1;
            if (step_reg == opdi_pkg::STEP_W'(opdi_pkg::NUM_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.cos_q30 = flip_reg ? -x_reg : x_reg;
    assign rsp.sin_q30 = flip_reg ? -y_reg : y_reg;

endmodule

[design/opdi_front.sv]
// ----------------------------------------------------------------------------
// opdi_front
// Input side: accepts poses into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module opdi_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  opdi_pkg::in_item_t s_data,
    output logic               q_valid,
    input  logic               q_pop,
    output opdi_pkg::in_item_t q_data
);

    opdi_pkg::in_item_t                mem_reg [opdi_pkg::QDEPTH];
    logic [opdi_pkg::QPTR_W-1:0]       wptr_reg, rptr_reg;
    logic [opdi_pkg::QPTR_W:0]         cnt_reg;
    logic                              push;
    logic                              pop;

    assign s_ready = (cnt_reg != 2'(opdi_pkg::QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_data  = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wptr_reg] <= s_data;
    end

    `include "odometry_pose_delta_integrator_assert.svh"
    `OPDI_ASSERT_IMP(a_no_overflow, aclk, aresetn, cnt_reg == 2'(opdi_pkg::QDEPTH), !push)
    `OPDI_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1, cnt_reg <= 2'(opdi_pkg::QDEPTH))
    `OPDI_ASSERT_IMP(a_ready_empty, aclk, aresetn, cnt_reg == '0, s_ready)

endmodule

[design/opdi_back.sv]
// ----------------------------------------------------------------------------
// opdi_back
// Execution side: keyframe delta, threshold test and path integration.
// ----------------------------------------------------------------------------
module opdi_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [15:0]        min_translation,
    input  logic [14:0]        min_rotation,
    input  logic               q_valid,
    output logic               q_pop,
    input  opdi_pkg::in_item_t q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output opdi_pkg::out_item_t m_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_KCORD, ST_MUL_A, ST_MUL_B, ST_DSUM, ST_TEST,
        ST_TCORD, ST_MUL_C, ST_MUL_D, ST_PSUM, ST_OUT
    } state_t;

    state_t              state_reg;
    opdi_pkg::in_item_t  item_reg;
    logic signed [15:0]  key_yaw_reg, track_yaw_reg;
    logic signed [31:0]  key_x_reg, key_y_reg, track_x_reg, track_y_reg;
    logic [31:0]         kept_reg;
    logic signed [33:0]  c_reg, s_reg;
    logic signed [32:0]  wx_reg, wy_reg;
    logic signed [65:0]  p0_reg, p1_reg;
    logic signed [31:0]  dx_reg, dy_reg;
    logic signed [15:0]  dyaw_reg;
    logic                acc_reg;
    logic                m_valid_reg;
    opdi_pkg::out_item_t m_data_reg;

    opdi_pkg::cordic_req_t creq;
    opdi_pkg::cordic_rsp_t crsp;

    logic signed [65:0]  sum_w;
    logic signed [65:0]  dot_w;
    logic [31:0]         adx, ady;
    logic [15:0]         adyaw;
    logic                below;

    opdi_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rsp     (crsp)
    );

    assign creq.start = (state_reg == ST_IDLE && q_valid && !m_valid_reg) ||
                        (state_reg == ST_TEST && !below);
    assign creq.angle = (state_reg == ST_IDLE) ? key_yaw_reg : track_yaw_reg;
    assign q_pop      = (state_reg == ST_IDLE && q_valid && !m_valid_reg);

    assign sum_w = p0_reg + p1_reg + 66'sd536870912;
    assign dot_w = sum_w >>> 30;

    assign adx   = dx_reg[31] ? (32'd0 - dx_reg) : dx_reg;
    assign ady   = dy_reg[31] ? (32'd0 - dy_reg) : dy_reg;
    assign adyaw = dyaw_reg[15] ? (16'd0 - dyaw_reg) : dyaw_reg;
    assign below = (adx < {16'd0, min_translation}) && (ady < {16'd0, min_translation}) &&
                   (adyaw < {1'b0, min_rotation});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            key_x_reg     <= '0;
            key_y_reg     <= '0;
            key_yaw_reg   <= '0;
            track_x_reg   <= '0;
            track_y_reg   <= '0;
            track_yaw_reg <= '0;
            kept_reg      <= '0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid && !m_valid_reg) begin
                        item_reg  <= q_data;
                        wx_reg    <= 33'(q_data.pose_x) - 33'(key_x_reg);
                        wy_reg    <= 33'(q_data.pose_y) - 33'(key_y_reg);
                        dyaw_reg  <= q_data.pose_yaw - key_yaw_reg;
                        state_reg <= ST_KCORD;
                    end
                end
                ST_KCORD: begin
                    if (crsp.done) begin
                        c_reg     <= crsp.cos_q30;
                        s_reg     <= crsp.sin_q30;
                        p0_reg    <= 66'(crsp.cos_q30) * 66'(wx_reg);
                        p1_reg    <= 66'(crsp.sin_q30) * 66'(wy_reg);
                        state_reg <= ST_MUL_A;
                    end
                end
                ST_MUL_A: begin
                    dx_reg    <= opdi_pkg::sat32(dot_w);
                    p0_reg    <= 66'(-s_reg) * 66'(wx_reg);
                    p1_reg    <= 66'(c_reg) * 66'(wy_reg);
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    dy_reg    <= opdi_pkg::sat32(dot_w);
                    state_reg <= ST_DSUM;
                end
                ST_DSUM: begin
                    state_reg <= ST_TEST;
                end
                ST_TEST: begin
                    acc_reg <= !below;
                    if (below) begin
                        state_reg <= ST_OUT;
                    end else begin
                        key_x_reg   <= item_reg.pose_x;
                        key_y_reg   <= item_reg.pose_y;
                        key_yaw_reg <= item_reg.pose_yaw;
                        state_reg   <= ST_TCORD;
                    end
                end
                ST_TCORD: begin
                    if (crsp.done) begin
                        c_reg     <= crsp.cos_q30;
                        s_reg     <= crsp.sin_q30;
                        p0_reg    <= 66'(crsp.cos_q30) * 66'(dx_reg);
                        p1_reg    <= 66'(-crsp.sin_q30) * 66'(dy_reg);
                        state_reg <= ST_MUL_C;
                    end
                end
                ST_MUL_C: begin
                    track_x_reg <= opdi_pkg::sat32(66'(track_x_reg) + dot_w);
                    p0_reg      <= 66'(s_reg) * 66'(dx_reg);
                    p1_reg      <= 66'(c_reg) * 66'(dy_reg);
                    state_reg   <= ST_MUL_D;
                end
                ST_MUL_D: begin
                    track_y_reg   <= opdi_pkg::sat32(66'(track_y_reg) + dot_w);
                    track_yaw_reg <= track_yaw_reg + dyaw_reg;
                    kept_reg      <= kept_reg + 32'd1;
                    state_reg     <= ST_PSUM;
                end
                ST_PSUM: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    m_data_reg.accepted       <= acc_reg;
                    m_data_reg.delta_x        <= dx_reg;
                    m_data_reg.delta_y        <= dy_reg;
                    m_data_reg.delta_yaw      <= dyaw_reg;
                    m_data_reg.path_x         <= track_x_reg;
                    m_data_reg.path_y         <= track_y_reg;
                    m_data_reg.path_yaw       <= track_yaw_reg;
                    m_data_reg.accepted_count <= kept_reg;
                    m_valid_reg               <= 1'b1;
                    state_reg                 <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `include "odometry_pose_delta_integrator_assert.svh"
    `OPDI_ASSERT_IMP(a_out_only_idle, aclk, aresetn, m_valid_reg && !m_ready && state_reg == ST_IDLE, !q_pop)
    `OPDI_ASSERT_NEXT(a_count_steps, aclk, aresetn, state_reg == ST_MUL_D, kept_reg == $past(kept_reg) + 32'd1)
    `OPDI_ASSERT_IMP(a_pop_idle, aclk, aresetn, q_pop, state_reg == ST_IDLE)

endmodule

[test/opdi_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// opdi_checker
// Watches both channels of the pose delta integrator, predicts each result
// from the accepted poses and the threshold settings, and compares fields.
// ----------------------------------------------------------------------------
module opdi_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  opdi_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  opdi_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata,
    output int                  fail_count,
    output int                  pending_count
);

    localparam longint ATAN_Q32 [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    logic [15:0] thr_trans;
    logic [14:0] thr_rot;
    longint kf_x, kf_y, kf_yaw, dr_x, dr_y, dr_yaw;
    logic [31:0] kept_num;
    opdi_pkg::out_item_t expected_results[$];

    assign pending_count = expected_results.size();

    // Arithmetic shifts on longint are floor shifts.
    function automatic void heading_sincos(input longint yaw, output longint c,
                                           output longint s);
        logic [31:0] ph;
        logic flip;
        longint z, x, y, nx;
        ph = {yaw[15:0], 16'h0};
        flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
        x = 652032874;
        y = 0;
        if (flip) begin
            ph = ph + 32'h8000_0000;
        end
        z = longint'($signed(ph));
        for (int i = 0; i < opdi_pkg::NUM_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_Q32[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_Q32[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint rotate_q30(input longint c, input longint a,
                                          input longint s, input longint b);
        return (c * a + s * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint wrap_turn(input longint v);
        return longint'($signed(v[15:0]));
    endfunction

    function automatic longint magnitude(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic opdi_pkg::out_item_t integrate_pose(input opdi_pkg::in_item_t p);
        opdi_pkg::out_item_t r;
        longint c, s, wx, wy, dx, dy, dyaw, px, py, pyaw;
        logic kept;
        px = p.pose_x;
        py = p.pose_y;
        pyaw = p.pose_yaw;
        heading_sincos(kf_yaw, c, s);
        wx = px - kf_x;
        wy = py - kf_y;
        dx = clamp32(rotate_q30(c, wx, s, wy));
        dy = clamp32(rotate_q30(-s, wx, c, wy));
        dyaw = wrap_turn(pyaw - kf_yaw);
        kept = !(magnitude(dx) < thr_trans && magnitude(dy) < thr_trans &&
                 magnitude(dyaw) < thr_rot);
        if (kept) begin
            kf_x = px;
            kf_y = py;
            kf_yaw = pyaw;
            heading_sincos(dr_yaw, c, s);
            dr_x = clamp32(dr_x + rotate_q30(c, dx, -s, dy));
            dr_y = clamp32(dr_y + rotate_q30(s, dx, c, dy));
            dr_yaw = wrap_turn(dr_yaw + dyaw);
            kept_num = kept_num + 1;
        end
        r.accepted = kept;
        r.delta_x = dx[31:0];
        r.delta_y = dy[31:0];
        r.delta_yaw = dyaw[15:0];
        r.path_x = dr_x[31:0];
        r.path_y = dr_y[31:0];
        r.path_yaw = dr_yaw[15:0];
        r.accepted_count = kept_num;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        opdi_pkg::out_item_t e;
        if (!aresetn) begin
            thr_trans <= opdi_pkg::RESET_MIN_TRANSLATION;
            thr_rot <= opdi_pkg::RESET_MIN_ROTATION;
            kf_x = 0; kf_y = 0; kf_yaw = 0;
            dr_x = 0; dr_y = 0; dr_yaw = 0;
            kept_num = 0;
            fail_count = 0;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == opdi_pkg::REG_MIN_TRANSLATION) thr_trans <= cfg_wdata;
                else thr_rot <= cfg_wdata[14:0];
            end
            if (s_valid && s_ready) begin
                expected_results = {expected_results, integrate_pose(s_data)};
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_data.accepted !== e.accepted)
                        report_mismatch("accepted", m_data.accepted, e.accepted);
                    if (m_data.delta_x !== e.delta_x)
                        report_mismatch("delta_x", m_data.delta_x, e.delta_x);
                    if (m_data.delta_y !== e.delta_y)
                        report_mismatch("delta_y", m_data.delta_y, e.delta_y);
                    if (m_data.delta_yaw !== e.delta_yaw)
                        report_mismatch("delta_yaw", m_data.delta_yaw, e.delta_yaw);
                    if (m_data.path_x !== e.path_x)
                        report_mismatch("path_x", m_data.path_x, e.path_x);
                    if (m_data.path_y !== e.path_y)
                        report_mismatch("path_y", m_data.path_y, e.path_y);
                    if (m_data.path_yaw !== e.path_yaw)
                        report_mismatch("path_yaw", m_data.path_yaw, e.path_yaw);
                    if (m_data.accepted_count !== e.accepted_count)
                        report_mismatch("accepted_count", m_data.accepted_count,
                                        e.accepted_count);
                end
            end
        end
    end
endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the pose delta integrator: directed and random poses under
// several threshold settings and idling patterns; a checker does the scoring.
// ----------------------------------------------------------------------------
module tb;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    opdi_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    opdi_pkg::out_item_t m_data;
    logic                cfg_we;
    logic                cfg_index;
    logic [15:0]         cfg_wdata;
    int                  fail_count;
    int                  pending_count;

    // Idle percentages of the sender and the receiver.
    int send_idle_pct;
    int recv_idle_pct;

    // Last pose sent; random walks step from it so most motion is small.
    opdi_pkg::in_item_t last_pose;

    odometry_pose_delta_integrator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    opdi_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver stalls at random; the ready level is redrawn every edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One pose transfer. Random idle cycles go in front, then valid is held
    // until the transfer completes. Valid is only lowered when no next pose
    // follows at once, so it never drops and rises in the same step.
    task automatic send_pose(input opdi_pkg::in_item_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_pose = p;
    endtask

    // Drop valid and wait until every expected result has been seen, then
    // give the back end time to finish anything still in flight.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic opdi_pkg::in_item_t pose_of(input logic [31:0] x,
                                                   input logic [31:0] y,
                                                   input logic [15:0] yaw);
        opdi_pkg::in_item_t p;
        p.pose_x = x;
        p.pose_y = y;
        p.pose_yaw = yaw;
        return p;
    endfunction

    // Mostly small steps from the last pose, sometimes big jumps, and now and
    // then a fully random pose so every bit of every field toggles.
    function automatic opdi_pkg::in_item_t random_pose();
        opdi_pkg::in_item_t p;
        int kind;
        kind = $urandom_range(99);
        p = last_pose;
        if (kind < 60) begin
            p.pose_x = p.pose_x + $signed($urandom_range(16000)) - 8000;
            p.pose_y = p.pose_y + $signed($urandom_range(16000)) - 8000;
            p.pose_yaw = p.pose_yaw + $signed(16'($urandom_range(2400))) - 16'sd1200;
        end else if (kind < 85) begin
            p.pose_x = p.pose_x + $signed($urandom_range(2000000)) - 1000000;
            p.pose_y = p.pose_y + $signed($urandom_range(2000000)) - 1000000;
            p.pose_yaw = 16'($urandom);
        end else begin
            p.pose_x = $urandom;
            p.pose_y = $urandom;
            p.pose_yaw = 16'($urandom);
        end
        return p;
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            send_pose(random_pose());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = opdi_pkg::REG_MIN_TRANSLATION;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        last_pose = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: tiny motions that are rejected under the reset
        // thresholds, motion just at the thresholds, pure rotations including
        // half a turn and yaw wrap, and position extremes that saturate the
        // delta and then the path.
        send_pose(pose_of(32'd100, -32'sd200, 16'sd10));
        send_pose(pose_of(32'd3276, 32'd0, 16'sd0));
        send_pose(pose_of(32'd3277, 32'd0, 16'sd0));
        send_pose(pose_of(32'd3277, 32'd0, 16'sd910));
        send_pose(pose_of(32'd3277, 32'd0, 16'sd1819));
        send_pose(pose_of(32'd3277, 32'd0, 16'sh8000));
        send_pose(pose_of(32'd3277, 32'd0, 16'sh7fff));
        send_pose(pose_of(32'd3277, 32'd0, 16'sh4000));
        send_pose(pose_of(32'd3277, 32'd0, 16'shc000));
        send_pose(pose_of(32'h7fffffff, 32'h7fffffff, 16'sh2000));
        send_pose(pose_of(32'h80000000, 32'h80000000, 16'sha000));
        send_pose(pose_of(32'h7fffffff, 32'h80000000, 16'sh6000));
        send_pose(pose_of(32'h80000000, 32'h7fffffff, 16'sh8000));
        send_pose(pose_of(32'h7fffffff, 32'h7fffffff, 16'sh0000));
        send_pose(pose_of(32'h80000000, 32'h80000000, 16'sh7fff));
        send_pose(pose_of(32'h7fffffff, 32'h80000000, 16'sh8001));
        send_pose(pose_of(32'd0, 32'd0, 16'sd0));
        send_pose(pose_of(32'hffffffff, 32'hffffffff, 16'shffff));
        // Hold off until the pipe is empty before the next pose.
        drain_results();
        send_pose(pose_of(32'd65536, -32'sd65536, 16'sd5000));

        // Zero thresholds: every motion, even none at all, is kept.
        drain_results();
        write_threshold(opdi_pkg::REG_MIN_TRANSLATION, 16'd0);
        write_threshold(opdi_pkg::REG_MIN_ROTATION, 16'd0);
        send_pose(last_pose);
        send_pose(last_pose);
        send_idle_pct = 25;
        recv_idle_pct = 52;
        random_phase(120);

        // Largest thresholds: small steps are mostly rejected.
        drain_results();
        write_threshold(opdi_pkg::REG_MIN_TRANSLATION, 16'hffff);
        write_threshold(opdi_pkg::REG_MIN_ROTATION, 16'h7fff);
        send_idle_pct = 52;
        recv_idle_pct = 25;
        random_phase(120);

        // Mid thresholds, with bit patterns opposite to each other.
        drain_results();
        write_threshold(opdi_pkg::REG_MIN_TRANSLATION, 16'h5555);
        write_threshold(opdi_pkg::REG_MIN_ROTATION, 16'h2aaa);
        random_phase(100);

        // Back to the reset values, no idling on either side.
        drain_results();
        write_threshold(opdi_pkg::REG_MIN_TRANSLATION, opdi_pkg::RESET_MIN_TRANSLATION);
        write_threshold(opdi_pkg::REG_MIN_ROTATION, {1'b0, opdi_pkg::RESET_MIN_ROTATION});
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(150);

        drain_results();
        if (fail_count == 0) begin
            $display("odometry_pose_delta_integrator verification clean");
        end else begin
            $display("odometry_pose_delta_integrator verification failed");
        end
        $finish;
    end

    // Timeout for the worst case of about 520 items plus stalls.
    initial begin
        #(3_000_000);
        $display("odometry_pose_delta_integrator verification failed");
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/opdi_pkg.sv
design/opdi_cordic.sv
design/opdi_front.sv
design/opdi_back.sv
design/odometry_pose_delta_integrator.sv
test/opdi_checker.sv
test/tb.sv
